### rtl/ils_pkg.sv
// Shared codes, widths and control types for the indexed list store.
package ils_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int WORD_W        = 32;
   localparam int MODE_W        = 3;
   localparam int POSITION_W    = 5;
   localparam int COUNT_W       = 5;
   localparam int STATUS_W      = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd5;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd6;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd7;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   // Per-cycle command broadcast along the cell row
   typedef struct packed {
      logic open_gap;   // shift towards the back from the index, write word there
      logic close_gap;  // shift towards the front onto the index
   } cell_ctrl_type;

endpackage

### rtl/indexed_list_store_core.sv
// Top level of the indexed list store: decode, cell row and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  req_    | in        | req_valid/req_stall  | req_mode, req_position, req_word_in
//  rsp_    | out       | rsp_valid/rsp_stall  | rsp_word_out, rsp_count, rsp_status
//
//  For every word, the cell row shifts or writes in the accepting
//  cycle and the result sits in the output register on the next cycle.
//  One word per cycle is sustained while rsp_stall is low.
//  req_stall rises only while a result is held in the output register under rsp_stall.
//  Reset empties the list and drops any pending result; the cells keep their contents.
module indexed_list_store_core #(
   parameter int DEPTH = ils_pkg::DEFAULT_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ils_pkg::MODE_W-1:0]            req_mode,
   input  logic [ils_pkg::POSITION_W-1:0]        req_position,
   input  logic signed [ils_pkg::WORD_W-1:0]     req_word_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ils_pkg::WORD_W-1:0]     rsp_word_out,
   output logic [ils_pkg::COUNT_W-1:0]           rsp_count,
   output logic [ils_pkg::STATUS_W-1:0]          rsp_status
);
   import ils_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PW    = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   logic                    accept;
   logic [CNT_W-1:0]        occupancy_ff;
   logic [CNT_W-1:0]        occupancy_in;
   cell_ctrl_type           dec_ctrl;
   cell_ctrl_type           cell_ctrl;
   logic [PW-1:0]           cell_pos;
   logic [STATUS_W-1:0]     dec_status;
   logic                    take_word;
   logic signed [WORD_W-1:0] cell_word [DEPTH];
   logic signed [WORD_W-1:0] cell_tap  [DEPTH];
   logic signed [WORD_W-1:0] gathered;
   logic [PW-1:0]           count_x;

   logic                    rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_word_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   ils_decode #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W),
      .PW    (PW)
   ) u_decode (
      .mode         (req_mode),
      .position     (req_position),
      .occupancy    (occupancy_ff),
      .ctrl         (dec_ctrl),
      .cell_pos     (cell_pos),
      .occupancy_nx (occupancy_in),
      .status       (dec_status),
      .take_word    (take_word)
   );

   // Hold the row still unless a word is taken
   assign cell_ctrl = accept ? dec_ctrl : '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] back_word;

      if (i == 0) begin : g_head
         assign front_word = '0;
      end else begin : g_link_front
         assign front_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign back_word = '0;
      end else begin : g_link_back
         assign back_word = cell_word[i+1];
      end

      ils_cell #(
         .INDEX (i),
         .PW    (PW)
      ) u_cell (
         .clock      (clock),
         .step       (accept),
         .ctrl       (cell_ctrl),
         .pos        (cell_pos),
         .word_in    (req_word_in),
         .from_front (front_word),
         .from_back  (back_word),
         .word       (cell_word[i]),
         .tap        (cell_tap[i])
      );
   end

   // At most one tap is non-zero
   always_comb begin
      gathered = '0;
      for (int i = 0; i < DEPTH; i++) begin
         gathered = gathered | cell_tap[i];
      end
   end

   assign count_x = PW'(occupancy_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            occupancy_ff <= occupancy_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff   <= take_word ? gathered : '0;
         rsp_count_ff  <= count_x[COUNT_W-1:0];
         rsp_status_ff <= dec_status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_out = rsp_word_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

### rtl/ils_cell.sv
// One storage cell of the list row: holds one word and trades it with its neighbours.
module ils_cell #(
   parameter int INDEX = 0,
   parameter int PW    = 5
) (
   input  logic                              clock,
   input  logic                              step,
   input  ils_pkg::cell_ctrl_type            ctrl,
   input  logic [PW-1:0]                     pos,
   input  logic signed [ils_pkg::WORD_W-1:0] word_in,
   input  logic signed [ils_pkg::WORD_W-1:0] from_front,
   input  logic signed [ils_pkg::WORD_W-1:0] from_back,
   output logic signed [ils_pkg::WORD_W-1:0] word,
   output logic signed [ils_pkg::WORD_W-1:0] tap
);
   import ils_pkg::*;

   localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in_nx;
   logic                     at_pos;
   logic                     behind_pos;

   assign at_pos     = (pos == MY_INDEX);
   assign behind_pos = (MY_INDEX > pos);

   always_comb begin
      word_in_nx = word_ff;
      if (ctrl.open_gap) begin
         if (behind_pos) begin
            word_in_nx = from_front;
         end else if (at_pos) begin
            word_in_nx = word_in;
         end
      end else if (ctrl.close_gap) begin
         if (behind_pos || at_pos) begin
            word_in_nx = from_back;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         word_ff <= word_in_nx;
      end
   end

   assign word = word_ff;
   // Offer the held word only when this cell is addressed
   assign tap  = at_pos ? word_ff : '0;

endmodule

### rtl/ils_decode.sv
// Operation decode: bound checks, cell command, next count and status.
module ils_decode #(
   parameter int DEPTH = ils_pkg::DEFAULT_DEPTH,
   parameter int CNT_W = 5,
   parameter int PW    = 5
) (
   input  logic [ils_pkg::MODE_W-1:0]     mode,
   input  logic [ils_pkg::POSITION_W-1:0] position,
   input  logic [CNT_W-1:0]               occupancy,
   output ils_pkg::cell_ctrl_type         ctrl,
   output logic [PW-1:0]                  cell_pos,
   output logic [CNT_W-1:0]               occupancy_nx,
   output logic [ils_pkg::STATUS_W-1:0]   status,
   output logic                           take_word
);
   import ils_pkg::*;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic          full;
   logic          empty;
   logic [PW-1:0] pos_x;
   logic [PW-1:0] occ_x;

   assign full  = (occupancy == FULL_COUNT);
   assign empty = (occupancy == '0);
   assign pos_x = PW'(position);
   assign occ_x = PW'(occupancy);

   always_comb begin
      ctrl         = '0;
      cell_pos     = '0;
      occupancy_nx = occupancy;
      status       = STATUS_OK;
      take_word    = 1'b0;
      case (mode)
         MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               ctrl.open_gap = 1'b1;
               cell_pos      = (mode == MODE_PUSH_BACK) ? occ_x : '0;
               occupancy_nx  = occupancy + 1'b1;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               ctrl.close_gap = 1'b1;
               take_word      = 1'b1;
               cell_pos       = (mode == MODE_POP_BACK) ? occ_x - 1'b1 : '0;
               occupancy_nx   = occupancy - 1'b1;
            end
         end
         MODE_INSERT: begin
            if (full) begin
               status = STATUS_FULL;
            end else if (pos_x > occ_x) begin
               status = STATUS_RANGE;
            end else begin
               ctrl.open_gap = 1'b1;
               cell_pos      = pos_x;
               occupancy_nx  = occupancy + 1'b1;
            end
         end
         MODE_REMOVE, MODE_READ: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else if (pos_x >= occ_x) begin
               status = STATUS_RANGE;
            end else begin
               take_word = 1'b1;
               cell_pos  = pos_x;
               if (mode == MODE_REMOVE) begin
                  ctrl.close_gap = 1'b1;
                  occupancy_nx   = occupancy - 1'b1;
               end
            end
         end
         MODE_CLEAR: begin
            occupancy_nx = '0;
         end
         default: begin
            occupancy_nx = '0;
         end
      endcase
   end

endmodule
